FILE: rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 digest block
// Word and chaining types, round constants, initial hash words and the
// control and status groups passed between the top level and the round core.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int FILL_W   = 6;
    localparam int COUNT_W  = 61;
    localparam int LEN_W    = 64;
    localparam int ROUND_W  = 7;
    localparam int WIN_D    = 16;

    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [4:0][WORD_W-1:0] chain_t;

    localparam chain_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                 32'hefcdab89, 32'h67452301};

    localparam word_t K_CH  = 32'h5a827999;
    localparam word_t K_PA1 = 32'h6ed9eba1;
    localparam word_t K_MAJ = 32'h8f1bbcdc;
    localparam word_t K_PA2 = 32'hca62c1d6;

    localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
    localparam logic [ROUND_W-1:0] ROUND_PA1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_MAJ   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PA2   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;

    localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_ZERO  = 8'h00;
    localparam logic [FILL_W-1:0] LEN_START = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [1:0]        LANE_LAST = 2'd3;

    typedef struct packed {
        logic push;
        logic start;
    } sha1_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } sha1_stat_t;

endpackage

FILE: rtl/sha1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_core: iterative SHA-1 compression unit
// Holds the 16-word message schedule window and the working variables, runs
// one round per cycle for 80 rounds and adds the result to the chaining value.
// ----------------------------------------------------------------------------
module sha1_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::sha1_ctrl_t ctrl,
    input  sha1_pkg::word_t     push_word,
    input  sha1_pkg::chain_t    chain_in,
    output sha1_pkg::sha1_stat_t stat,
    output sha1_pkg::chain_t    chain_sum
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    core_state_t          state_reg;
    logic [ROUND_W-1:0]   round_reg;
    word_t                a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t                win_reg [WIN_D];

    word_t                sched_mix;
    word_t                sched_word;
    word_t                w_cur;
    word_t                f_val;
    word_t                k_val;
    word_t                t_next;

    // Schedule taps: win_reg[0] is w[t-16], [2] is w[t-14], [8] is w[t-8],
    // [13] is w[t-3] once the first sixteen rounds have passed.
    always_comb
    begin
        sched_mix  = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        sched_word = {sched_mix[WORD_W-2:0], sched_mix[WORD_W-1]};
        w_cur      = (round_reg < ROUND_SCHED) ? win_reg[0] : sched_word;

        if (round_reg < ROUND_PA1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_CH;
        end
        else if (round_reg < ROUND_MAJ)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_PA1;
        end
        else if (round_reg < ROUND_PA2)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_MAJ;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_PA2;
        end

        t_next = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]} + f_val + e_reg
                 + k_val + w_cur;
    end

    assign chain_sum[0] = chain_in[0] + a_reg;
    assign chain_sum[1] = chain_in[1] + b_reg;
    assign chain_sum[2] = chain_in[2] + c_reg;
    assign chain_sum[3] = chain_in[3] + d_reg;
    assign chain_sum[4] = chain_in[4] + e_reg;

    assign stat.idle = (state_reg == C_IDLE);
    assign stat.done = (state_reg == C_ADD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        round_reg <= '0;
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == ROUND_LAST)
                    begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Working variables and schedule window carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && ctrl.start)
        begin
            a_reg <= chain_in[0];
            b_reg <= chain_in[1];
            c_reg <= chain_in[2];
            d_reg <= chain_in[3];
            e_reg <= chain_in[4];
        end
        else if (state_reg == C_ROUND)
        begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end

        if (ctrl.push || state_reg == C_ROUND)
        begin
            for (int i = 0; i < WIN_D - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_D-1] <= ctrl.push ? push_word : w_cur;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == C_IDLE)
        else $error("compression started while the core was busy");

    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> state_reg == C_IDLE)
        else $error("schedule word pushed during compression");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(state_reg == C_ROUND && round_reg == ROUND_LAST))
        else $error("add cycle reached without the last round");

endmodule

FILE: rtl/sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest: SHA-1 hash over a byte stream
// Packs message bytes big-endian into 32-bit words, compresses each full
// 64-byte block, and on a finish beat pads the message, appends the bit
// length and returns the five digest words before starting a new message.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Direction | Beat
//  --------+------------------------------------------+-----------+-----------------
//  in      | in_valid, in_stall, mode, data_byte      | in        | one byte/finish
//  out     | out_valid, out_stall, digest_h0..h4      | out       | one digest
//
// The beat that completes a 64-byte block starts the round core, which runs
// its 80 rounds and then the add.
// A finish beat feeds the padding and the length through the same byte path at
// one byte per cycle (64 - fill bytes, or 128 - fill when more than 55 bytes are
// pending), paused for one or two compressions, then an emit step.
// After reset the block is ready at once; the block buffer needs no clearing.
// The input is stalled whenever a block is being compressed, padded or emitted.
// A digest that waits on a stalled output holds up the next emit step.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [sha1_pkg::BYTE_W-1:0]  data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sha1_pkg::WORD_W-1:0]  digest_h0,
    output logic [sha1_pkg::WORD_W-1:0]  digest_h1,
    output logic [sha1_pkg::WORD_W-1:0]  digest_h2,
    output logic [sha1_pkg::WORD_W-1:0]  digest_h3,
    output logic [sha1_pkg::WORD_W-1:0]  digest_h4
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_HASH,
        S_EMIT
    } state_t;

    state_t               state_reg;
    chain_t               chain_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 pad_reg;     // finishing: padding bytes are being fed
    logic                 extra_reg;   // the current padded block is not the last
    logic                 final_reg;   // the running compression ends the message
    logic                 out_valid_reg;
    chain_t               digest_reg;
    word_t                word_reg;
    logic [LEN_W-1:0]     len_reg;

    logic                 accept;
    logic                 push_byte;
    logic [BYTE_W-1:0]    byte_val;
    logic                 len_phase;
    logic                 block_full;
    sha1_ctrl_t           core_ctrl;
    sha1_stat_t           core_stat;
    chain_t               chain_sum;
    word_t                push_word;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign digest_h0 = digest_reg[0];
    assign digest_h1 = digest_reg[1];
    assign digest_h2 = digest_reg[2];
    assign digest_h3 = digest_reg[3];
    assign digest_h4 = digest_reg[4];

    // Byte source: an accepted beat (message byte or the 0x80 marker), or the
    // padding sequencer, which sends zeros and then the big-endian bit length.
    always_comb
    begin
        len_phase = (state_reg == S_PAD) && (fill_reg >= LEN_START) && !extra_reg;
        push_byte = accept || (state_reg == S_PAD);
        if (state_reg == S_PAD)
        begin
            byte_val = len_phase ? len_reg[LEN_W-1 -: BYTE_W] : PAD_ZERO;
        end
        else
        begin
            byte_val = mode ? PAD_MARK : data_byte;
        end
        push_word       = {word_reg[WORD_W-BYTE_W-1:0], byte_val};
        block_full      = push_byte && (fill_reg == FILL_LAST);
        core_ctrl.push  = push_byte && (fill_reg[1:0] == LANE_LAST);
        core_ctrl.start = block_full;
    end

    sha1_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (core_ctrl),
        .push_word (push_word),
        .chain_in  (chain_reg),
        .stat      (core_stat),
        .chain_sum (chain_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chain_reg     <= H_INIT;
            count_reg     <= '0;
            fill_reg      <= '0;
            pad_reg       <= 1'b0;
            extra_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            digest_reg    <= '0;
        end
        else
        begin
            // The emit step owns the valid flag while it runs.
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            if (push_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!mode)
                        begin
                            count_reg <= count_reg + 61'd1;
                        end
                        else
                        begin
                            pad_reg   <= 1'b1;
                            // A marker that fills the block still leaves the
                            // length for a following block.
                            extra_reg <= !block_full && (fill_reg >= LEN_START);
                        end
                        final_reg <= 1'b0;
                        if (block_full)
                        begin
                            state_reg <= S_HASH;
                        end
                        else if (mode)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (block_full)
                    begin
                        final_reg <= !extra_reg;
                        extra_reg <= 1'b0;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (core_stat.done)
                    begin
                        chain_reg <= chain_sum;
                        if (final_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else if (pad_reg)
                        begin
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        digest_reg    <= chain_reg;
                        out_valid_reg <= 1'b1;
                        chain_reg     <= H_INIT;
                        count_reg     <= '0;
                        pad_reg       <= 1'b0;
                        final_reg     <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Byte packing and the length shifter carry no reset.
    always_ff @(posedge clk)
    begin
        if (push_byte)
        begin
            word_reg <= push_word;
        end
        if (accept && mode)
        begin
            len_reg <= {count_reg, 3'b000};
        end
        else if (len_phase)
        begin
            len_reg <= {len_reg[LEN_W-BYTE_W-1:0], PAD_ZERO};
        end
    end

    a_start_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.start |-> fill_reg == FILL_LAST && core_stat.idle)
        else $error("compression started on a partial block or busy core");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("digest beat raised outside the emit step");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> count_reg == '0 && fill_reg == '0 && !pad_reg)
        else $error("message state not reinitialized after a digest");

    a_no_push_hash: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HASH |-> !push_byte && !core_stat.idle)
        else $error("byte pushed or core idle while hashing");

endmodule

FILE: dv/sha1_message_digest_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for the sha1_message_digest block
// Streams whole messages of absorb beats, each closed by a finish beat, into
// the digest block. A local SHA-1 predictor works out the digest of every
// message as its finish beat is accepted, and each digest beat that leaves
// the block is checked word by word against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

    import sha1_pkg::*;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [4:0][WORD_W-1:0] digest_t;

    // Beat kinds carried on the mode port.
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Idle and stall odds, in percent per cycle.
    localparam int GAP_PCT = 22;

    // Watchdog bound on the whole run, including stretches under heavy stalls;
    // it leaves a wide margin above the length of the run.
    localparam int CYCLE_LIMIT = 2000000;

    // A finish beat after 56 or more pending bytes costs a second padded block
    // and two compressions, so this covers the worst tail.
    localparam int TAIL_CYCLES = 320;

    localparam int RANDOM_BEATS = 1500;
    localparam int RANDOM_DIGESTS = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_ABSORB;
    byte_t       data_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    word_t       digest_h0;
    word_t       digest_h1;
    word_t       digest_h2;
    word_t       digest_h3;
    word_t       digest_h4;

    // When clear, neither the sender nor the receiver inserts gaps.
    bit          gaps_on = 1'b1;
    int          error_count = 0;
    int          beats_sent = 0;
    int          digests_predicted = 0;
    int          cycle_count = 0;

    // Digests that the predictor has produced and the block has not yet
    // delivered, oldest first.
    digest_t     pending_digests[$];

    // Predictor state: chaining words, the block being filled, the running
    // byte count (61 bits, so the bit length wraps at 2^64) and the fill index.
    word_t              hash_words[5];
    byte_t              block_bytes[64];
    logic [60:0]        msg_len_bytes;
    logic [5:0]         fill_idx;

    sha1_message_digest u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digest_h0 (digest_h0),
        .digest_h1 (digest_h1),
        .digest_h2 (digest_h2),
        .digest_h3 (digest_h3),
        .digest_h4 (digest_h4)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // SHA-1 predictor
    // ------------------------------------------------------------------------

    function automatic word_t rotl(word_t v, int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // Return the chaining words, count and fill index to a fresh message.
    // The block bytes are left alone: padding always overwrites whatever
    // absorb beats did not fill.
    function automatic void start_message();
        hash_words[0] = 32'h67452301;
        hash_words[1] = 32'hefcdab89;
        hash_words[2] = 32'h98badcfe;
        hash_words[3] = 32'h10325476;
        hash_words[4] = 32'hc3d2e1f0;
        msg_len_bytes = '0;
        fill_idx = '0;
    endfunction

    // Run the 80-round compression of the current block into hash_words.
    function automatic void compress_block();
        word_t sched[80];
        word_t a, b, c, d, e, f, k, sum;
        for (int t = 0; t < 16; t++)
        begin
            sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        for (int t = 16; t < 80; t++)
        begin
            sched[t] = rotl(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
        end
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            sum = rotl(a, 5) + f + e + k + sched[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    function automatic void absorb_byte(byte_t value);
        block_bytes[fill_idx] = value;
        msg_len_bytes += 1;
        fill_idx += 1;
        if (fill_idx == 0)
        begin
            compress_block();
        end
    endfunction

    // Pad, append the bit length, and return the finished digest. More than
    // 55 pending bytes leave no room for the length, so an extra block is
    // compressed first.
    function automatic digest_t finish_message();
        logic [63:0] bit_len;
        int          pos;
        digest_t     result;
        bit_len = {msg_len_bytes, 3'b000};
        pos = fill_idx;
        block_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
        begin
            block_bytes[63-i] = bit_len[8*i +: 8];
        end
        compress_block();
        for (int i = 0; i < 5; i++)
        begin
            result[i] = hash_words[i];
        end
        start_message();
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sha1_message_digest regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls at random while gaps are enabled, and checks every
    // accepted digest beat against the oldest prediction.
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < GAP_PCT);
    end

    always @(posedge clk)
    begin : digest_check
        digest_t observed;
        digest_t wanted;
        if (rst_n && out_valid && !out_stall)
        begin
            observed = {digest_h4, digest_h3, digest_h2, digest_h1, digest_h0};
            if (pending_digests.size() == 0)
            begin
                error_count++;
                $display("%0t: digest beat %h arrived with nothing pending",
                         $time, observed);
            end
            else
            begin
                wanted = pending_digests.pop_front();
                for (int i = 0; i < 5; i++)
                begin
                    if (observed[i] !== wanted[i])
                    begin
                        error_count++;
                        $display("%0t: digest_h%0d expected %08h, actual %08h",
                                 $time, i, wanted[i], observed[i]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Present one beat from a falling edge and hold it until the block takes
    // it. A random number of idle cycles may come first. On acceptance the
    // predictor is advanced, and a finish beat queues its digest.
    task automatic send_beat(input logic kind, input byte_t value);
        digest_t predicted;
        @(negedge clk);
        while (gaps_on && ($urandom_range(0, 99) < GAP_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= kind;
        data_byte <= value;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        beats_sent++;
        if (kind == MODE_ABSORB)
        begin
            absorb_byte(value);
        end
        else
        begin
            predicted = finish_message();
            pending_digests = {pending_digests, predicted};
            digests_predicted++;
        end
    endtask

    // A message of random bytes; the finish beat carries a random byte that
    // the block has to ignore.
    task automatic send_random_message(input int length);
        for (int i = 0; i < length; i++)
        begin
            send_beat(MODE_ABSORB, byte_t'($urandom_range(0, 255)));
        end
        send_beat(MODE_FINISH, byte_t'($urandom_range(0, 255)));
    endtask

    // Drop the last beat before the next edge so it is not taken twice, then
    // wait for every pending digest.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digests.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly short messages, so digests come often, with a good share of
    // lengths right at the padding and block edges and some long ones.
    function automatic int pick_length();
        int edges[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
        begin
            return $urandom_range(0, 20);
        end
        else if (roll < 8)
        begin
            return edges[$urandom_range(0, 7)];
        end
        return $urandom_range(0, 140);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The empty message, finished once with all data bits set and once with
    // none set, both of which must be ignored.
    task automatic test_empty_message();
        send_beat(MODE_FINISH, 8'hff);
        send_beat(MODE_FINISH, 8'h00);
    endtask

    // One-byte messages at both extremes of the byte value.
    task automatic test_single_byte_messages();
        send_beat(MODE_ABSORB, 8'h00);
        send_beat(MODE_FINISH, 8'h00);
        send_beat(MODE_ABSORB, 8'hff);
        send_beat(MODE_FINISH, 8'hff);
    endtask

    // The classic three-letter text.
    task automatic test_known_text();
        send_beat(MODE_ABSORB, 8'h61);
        send_beat(MODE_ABSORB, 8'h62);
        send_beat(MODE_ABSORB, 8'h63);
        send_beat(MODE_FINISH, 8'h5a);
    endtask

    // Lengths around the point where the length field no longer fits and
    // around whole blocks, with random content.
    task automatic test_block_boundaries();
        int lengths[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        foreach (lengths[i])
        begin
            send_random_message(lengths[i]);
        end
    endtask

    // Hold the sender back until every digest has come out, after each of a
    // few messages, so each one starts on an idle block.
    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
        begin
            send_random_message(pick_length());
            wait_until_drained();
        end
    endtask

    // A long stretch with no idle cycles on either side.
    task automatic test_back_to_back();
        int start_beats;
        start_beats = beats_sent;
        gaps_on = 1'b0;
        while (beats_sent - start_beats < 300)
        begin
            send_random_message(pick_length());
        end
        gaps_on = 1'b1;
    endtask

    // The bulk of the run: random messages until enough beats and enough
    // digests have gone through.
    task automatic test_random_messages();
        while (beats_sent < RANDOM_BEATS || digests_predicted < RANDOM_DIGESTS)
        begin
            send_random_message(pick_length());
        end
    endtask

    initial
    begin
        start_message();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_single_byte_messages();
        test_known_text();
        test_block_boundaries();
        test_drain_pause();
        test_back_to_back();
        test_random_messages();

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("sha1_message_digest regression: pass");
        end
        else
        begin
            $display("sha1_message_digest regression: fail");
        end
        $finish;
    end

endmodule
